/* hw/rtl/gpio_pin_controller_assert.svh */
// Assertion macros for the GPIO pin controller.
// ASSERT_NOW checks a consequent in the same cycle, ASSERT_NEXT in the cycle after.
`ifndef GPIO_PIN_CONTROLLER_ASSERT_SVH
`define GPIO_PIN_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define GPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpio_pin_controller: check failed");
`define GPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpio_pin_controller: check failed");
`else
`define GPC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define GPC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/gpc_pkg.sv */
package gpc_pkg;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   localparam int WORD_BITS     = 32;
   localparam int VEC_BITS      = 64;
   localparam int INDEX_BITS    = 6;
   localparam int FSEL_WORDS    = 6;
   localparam int FSEL_PER_WORD = 10;
   localparam int FSEL_BITS     = 3;

   localparam logic [FSEL_BITS-1:0] FSEL_OUTPUT = 3'd1;

   localparam logic [1:0] PULL_DOWN = 2'd1;
   localparam logic [1:0] PULL_UP   = 2'd2;

   // register word indexes
   localparam logic [INDEX_BITS-1:0] REG_SET_LO   = 6'd7;
   localparam logic [INDEX_BITS-1:0] REG_SET_HI   = 6'd8;
   localparam logic [INDEX_BITS-1:0] REG_CLR_LO   = 6'd10;
   localparam logic [INDEX_BITS-1:0] REG_CLR_HI   = 6'd11;
   localparam logic [INDEX_BITS-1:0] REG_LEV_LO   = 6'd13;
   localparam logic [INDEX_BITS-1:0] REG_LEV_HI   = 6'd14;
   localparam logic [INDEX_BITS-1:0] REG_EVT_LO   = 6'd16;
   localparam logic [INDEX_BITS-1:0] REG_EVT_HI   = 6'd17;
   localparam logic [INDEX_BITS-1:0] REG_RISE_LO  = 6'd19;
   localparam logic [INDEX_BITS-1:0] REG_RISE_HI  = 6'd20;
   localparam logic [INDEX_BITS-1:0] REG_FALL_LO  = 6'd22;
   localparam logic [INDEX_BITS-1:0] REG_FALL_HI  = 6'd23;
   localparam logic [INDEX_BITS-1:0] REG_ARISE_LO = 6'd31;
   localparam logic [INDEX_BITS-1:0] REG_ARISE_HI = 6'd32;
   localparam logic [INDEX_BITS-1:0] REG_AFALL_LO = 6'd34;
   localparam logic [INDEX_BITS-1:0] REG_AFALL_HI = 6'd35;
   localparam logic [INDEX_BITS-1:0] REG_PULL     = 6'd37;
   localparam logic [INDEX_BITS-1:0] REG_PCLK_LO  = 6'd38;
   localparam logic [INDEX_BITS-1:0] REG_PCLK_HI  = 6'd39;

   localparam logic [VEC_BITS-1:0] KEEP_LOW  = 64'h0000_0000_FFFF_FFFF;
   localparam logic [VEC_BITS-1:0] KEEP_HIGH = 64'hFFFF_FFFF_0000_0000;

   typedef struct packed {
      logic                  valid;
      func_type              func;
      logic [INDEX_BITS-1:0] index;
      logic [WORD_BITS-1:0]  data;
   } cmd_type;

endpackage

/* hw/rtl/gpio_pin_controller.sv */
// GPIO pin controller: a 40-word register bank over PIN_COUNT pins.
// Request channel: drive req_func, req_reg_index, req_write_data and
// req_pin_levels with start high; the transaction is taken at the clock
// edge where start is high and busy is low. busy stays low, so a new
// transaction may be issued in every cycle.
// req_func selects a register write, a register read or a sample tick that
// loads the pin levels and updates the edge event status.
// Response channel: rsp_valid rises at the first edge after the request was
// taken and stays high for exactly one cycle. rsp_read_data carries the
// read word (zero for writes and ticks); the pin vectors and rsp_event_irq
// show the state after the transaction. The receiver cannot stall: each
// response is taken in the cycle it is shown, and the vector ports hold
// their value between responses.
// Throughput is one transaction per cycle: a request register feeds one
// pass of decode and update logic into the state and read-data registers.
// Reset (synchronous, active high) clears all state: every pin an input,
// output latch, enables, event status, pull code and pull latches zero,
// and drops any transaction in flight.
`include "gpio_pin_controller_assert.svh"

module gpio_pin_controller #(
   parameter int PIN_COUNT = 54
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_func,
   input  logic [gpc_pkg::INDEX_BITS-1:0] req_reg_index,
   input  logic [gpc_pkg::WORD_BITS-1:0] req_write_data,
   input  logic [PIN_COUNT-1:0]          req_pin_levels,
   output logic                          rsp_valid,
   output logic [gpc_pkg::WORD_BITS-1:0] rsp_read_data,
   output logic [PIN_COUNT-1:0]          rsp_out_levels,
   output logic [PIN_COUNT-1:0]          rsp_out_enable,
   output logic [PIN_COUNT-1:0]          rsp_pull_up_pins,
   output logic [PIN_COUNT-1:0]          rsp_pull_down_pins,
   output logic                          rsp_event_irq
);

   logic req_accept;
   logic cmd_not_read;

   gpc_pkg::cmd_type     cmd_ff, cmd_in;
   logic [PIN_COUNT-1:0] pins_ff;
   logic                 rsp_valid_ff;
   logic [gpc_pkg::WORD_BITS-1:0] read_data_ff, read_data_in;

   // every cycle can take a transaction
   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   always_comb begin
      cmd_in.valid = req_accept;
      cmd_in.func  = gpc_pkg::func_type'(req_func);
      cmd_in.index = req_reg_index;
      cmd_in.data  = req_write_data;
   end

   // request register: hold the transaction for the update pass
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff.valid <= 1'b0;
      end else begin
         cmd_ff <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      pins_ff <= req_pin_levels;
   end

   // decode, update state and select the read word in one pass
   gpc_regs #(
      .PIN_COUNT(PIN_COUNT)
   ) u_regs (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd_ff),
      .pin_levels    (pins_ff),
      .read_word     (read_data_in),
      .out_levels    (rsp_out_levels),
      .out_enable    (rsp_out_enable),
      .pull_up_pins  (rsp_pull_up_pins),
      .pull_down_pins(rsp_pull_down_pins),
      .event_irq     (rsp_event_irq)
   );

   // response register: advance the strobe with the updated state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = read_data_ff;

   assign cmd_not_read = cmd_ff.valid && (cmd_ff.func != gpc_pkg::FUNC_READ);

   `GPC_ASSERT_NEXT(a_req_to_cmd, clock, reset, req_accept, cmd_ff.valid)
   `GPC_ASSERT_NEXT(a_cmd_to_rsp, clock, reset, cmd_ff.valid, rsp_valid)
   `GPC_ASSERT_NEXT(a_rd_zero, clock, reset, cmd_not_read, rsp_read_data == '0)

endmodule

/* hw/rtl/gpc_regs.sv */
`include "gpio_pin_controller_assert.svh"

module gpc_regs #(
   parameter int PIN_COUNT = 54
) (
   input  logic                           clock,
   input  logic                           reset,
   input  gpc_pkg::cmd_type               cmd,
   input  logic [PIN_COUNT-1:0]           pin_levels,
   output logic [gpc_pkg::WORD_BITS-1:0]  read_word,
   output logic [PIN_COUNT-1:0]           out_levels,
   output logic [PIN_COUNT-1:0]           out_enable,
   output logic [PIN_COUNT-1:0]           pull_up_pins,
   output logic [PIN_COUNT-1:0]           pull_down_pins,
   output logic                           event_irq
);

   localparam int FSEL_SLOTS = gpc_pkg::FSEL_WORDS * gpc_pkg::FSEL_PER_WORD;

   logic wr, rd, tick;
   assign wr   = cmd.valid && (cmd.func == gpc_pkg::FUNC_WRITE);
   assign rd   = cmd.valid && (cmd.func == gpc_pkg::FUNC_READ);
   assign tick = cmd.valid && (cmd.func == gpc_pkg::FUNC_TICK);

   // function select: one 3-bit register per present pin, absent slots read zero
   wire [FSEL_SLOTS-1:0][gpc_pkg::FSEL_BITS-1:0]               fsel_all;
   logic [gpc_pkg::FSEL_WORDS-1:0][gpc_pkg::FSEL_PER_WORD*gpc_pkg::FSEL_BITS-1:0] fsel_word;

   for (genvar p = 0; p < FSEL_SLOTS; p++) begin : g_fsel
      if (p < PIN_COUNT) begin : g_pin
         localparam int W = p / gpc_pkg::FSEL_PER_WORD;
         localparam int K = p % gpc_pkg::FSEL_PER_WORD;
         logic [gpc_pkg::FSEL_BITS-1:0] sel_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               sel_ff <= '0;
            end else if (wr && (cmd.index == gpc_pkg::INDEX_BITS'(W))) begin
               sel_ff <= cmd.data[gpc_pkg::FSEL_BITS*K +: gpc_pkg::FSEL_BITS];
            end
         end
         assign fsel_all[p] = sel_ff;
      end else begin : g_absent
         assign fsel_all[p] = '0;
      end
   end

   assign fsel_word = fsel_all;

   for (genvar p = 0; p < PIN_COUNT; p++) begin : g_oe
      if (p < FSEL_SLOTS) begin : g_mapped
         assign out_enable[p] = (fsel_all[p] == gpc_pkg::FSEL_OUTPUT);
      end else begin : g_unmapped
         assign out_enable[p] = 1'b0;
      end
   end

   // pin vectors
   logic [PIN_COUNT-1:0] out_ff, level_ff, event_ff, rise_ff, fall_ff;
   logic [PIN_COUNT-1:0] arise_ff, afall_ff, pu_ff, pd_ff;
   logic [1:0]           pull_code_ff;

   logic [gpc_pkg::VEC_BITS-1:0] out64, level64, event64, rise64, fall64;
   logic [gpc_pkg::VEC_BITS-1:0] arise64, afall64, pu64, pd64, pins64;
   logic [gpc_pkg::VEC_BITS-1:0] lo64, hi64;

   logic [gpc_pkg::VEC_BITS-1:0] out_in, level_in, event_in, rise_in, fall_in;
   logic [gpc_pkg::VEC_BITS-1:0] arise_in, afall_in, pu_in, pd_in;
   logic [1:0]                   pull_code_in;

   always_comb begin
      out64   = '0;
      level64 = '0;
      event64 = '0;
      rise64  = '0;
      fall64  = '0;
      arise64 = '0;
      afall64 = '0;
      pu64    = '0;
      pd64    = '0;
      pins64  = '0;
      out64[PIN_COUNT-1:0]   = out_ff;
      level64[PIN_COUNT-1:0] = level_ff;
      event64[PIN_COUNT-1:0] = event_ff;
      rise64[PIN_COUNT-1:0]  = rise_ff;
      fall64[PIN_COUNT-1:0]  = fall_ff;
      arise64[PIN_COUNT-1:0] = arise_ff;
      afall64[PIN_COUNT-1:0] = afall_ff;
      pu64[PIN_COUNT-1:0]    = pu_ff;
      pd64[PIN_COUNT-1:0]    = pd_ff;
      pins64[PIN_COUNT-1:0]  = pin_levels;
   end

   assign lo64 = {32'h0, cmd.data};
   assign hi64 = {cmd.data, 32'h0};

   always_comb begin
      out_in       = out64;
      level_in     = level64;
      event_in     = event64;
      rise_in      = rise64;
      fall_in      = fall64;
      arise_in     = arise64;
      afall_in     = afall64;
      pu_in        = pu64;
      pd_in        = pd64;
      pull_code_in = pull_code_ff;
      if (wr) begin
         case (cmd.index)
            gpc_pkg::REG_SET_LO:   out_in   = out64 | lo64;
            gpc_pkg::REG_SET_HI:   out_in   = out64 | hi64;
            gpc_pkg::REG_CLR_LO:   out_in   = out64 & ~lo64;
            gpc_pkg::REG_CLR_HI:   out_in   = out64 & ~hi64;
            gpc_pkg::REG_EVT_LO:   event_in = event64 & ~lo64;
            gpc_pkg::REG_EVT_HI:   event_in = event64 & ~hi64;
            gpc_pkg::REG_RISE_LO:  rise_in  = (rise64 & gpc_pkg::KEEP_HIGH) | lo64;
            gpc_pkg::REG_RISE_HI:  rise_in  = (rise64 & gpc_pkg::KEEP_LOW) | hi64;
            gpc_pkg::REG_FALL_LO:  fall_in  = (fall64 & gpc_pkg::KEEP_HIGH) | lo64;
            gpc_pkg::REG_FALL_HI:  fall_in  = (fall64 & gpc_pkg::KEEP_LOW) | hi64;
            gpc_pkg::REG_ARISE_LO: arise_in = (arise64 & gpc_pkg::KEEP_HIGH) | lo64;
            gpc_pkg::REG_ARISE_HI: arise_in = (arise64 & gpc_pkg::KEEP_LOW) | hi64;
            gpc_pkg::REG_AFALL_LO: afall_in = (afall64 & gpc_pkg::KEEP_HIGH) | lo64;
            gpc_pkg::REG_AFALL_HI: afall_in = (afall64 & gpc_pkg::KEEP_LOW) | hi64;
            gpc_pkg::REG_PULL:     pull_code_in = cmd.data[1:0];
            gpc_pkg::REG_PCLK_LO: begin
               pu_in = (pu64 & ~lo64) | ((pull_code_ff == gpc_pkg::PULL_UP) ? lo64 : '0);
               pd_in = (pd64 & ~lo64) | ((pull_code_ff == gpc_pkg::PULL_DOWN) ? lo64 : '0);
            end
            gpc_pkg::REG_PCLK_HI: begin
               pu_in = (pu64 & ~hi64) | ((pull_code_ff == gpc_pkg::PULL_UP) ? hi64 : '0);
               pd_in = (pd64 & ~hi64) | ((pull_code_ff == gpc_pkg::PULL_DOWN) ? hi64 : '0);
            end
            default: ;
         endcase
      end else if (tick) begin
         // edges against the previous sample, gated by sync or async enables
         level_in = pins64;
         event_in = event64 | (pins64 & ~level64 & (rise64 | arise64))
                            | (~pins64 & level64 & (fall64 | afall64));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff       <= '0;
         level_ff     <= '0;
         event_ff     <= '0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         arise_ff     <= '0;
         afall_ff     <= '0;
         pu_ff        <= '0;
         pd_ff        <= '0;
         pull_code_ff <= '0;
      end else begin
         out_ff       <= out_in[PIN_COUNT-1:0];
         level_ff     <= level_in[PIN_COUNT-1:0];
         event_ff     <= event_in[PIN_COUNT-1:0];
         rise_ff      <= rise_in[PIN_COUNT-1:0];
         fall_ff      <= fall_in[PIN_COUNT-1:0];
         arise_ff     <= arise_in[PIN_COUNT-1:0];
         afall_ff     <= afall_in[PIN_COUNT-1:0];
         pu_ff        <= pu_in[PIN_COUNT-1:0];
         pd_ff        <= pd_in[PIN_COUNT-1:0];
         pull_code_ff <= pull_code_in;
      end
   end

   // read mux; write-only and unmapped words read zero
   always_comb begin
      read_word = '0;
      if (rd) begin
         if (cmd.index < gpc_pkg::INDEX_BITS'(gpc_pkg::FSEL_WORDS)) begin
            read_word = {2'b00, fsel_word[cmd.index[2:0]]};
         end else begin
            case (cmd.index)
               gpc_pkg::REG_LEV_LO:   read_word = level64[31:0];
               gpc_pkg::REG_LEV_HI:   read_word = level64[63:32];
               gpc_pkg::REG_EVT_LO:   read_word = event64[31:0];
               gpc_pkg::REG_EVT_HI:   read_word = event64[63:32];
               gpc_pkg::REG_RISE_LO:  read_word = rise64[31:0];
               gpc_pkg::REG_RISE_HI:  read_word = rise64[63:32];
               gpc_pkg::REG_FALL_LO:  read_word = fall64[31:0];
               gpc_pkg::REG_FALL_HI:  read_word = fall64[63:32];
               gpc_pkg::REG_ARISE_LO: read_word = arise64[31:0];
               gpc_pkg::REG_ARISE_HI: read_word = arise64[63:32];
               gpc_pkg::REG_AFALL_LO: read_word = afall64[31:0];
               gpc_pkg::REG_AFALL_HI: read_word = afall64[63:32];
               gpc_pkg::REG_PULL:     read_word = {30'h0, pull_code_ff};
               default:               read_word = '0;
            endcase
         end
      end
   end

   assign out_levels     = out_ff;
   assign pull_up_pins   = pu_ff;
   assign pull_down_pins = pd_ff;
   assign event_irq      = |event_ff;

   `GPC_ASSERT_NEXT(a_evt_quiet, clock, reset, tick && ((rise_ff | fall_ff | arise_ff | afall_ff) == '0), event_ff == $past(event_ff))
   `GPC_ASSERT_NEXT(a_set_keeps, clock, reset, wr && ((cmd.index == gpc_pkg::REG_SET_LO) || (cmd.index == gpc_pkg::REG_SET_HI)), (out_ff & $past(out_ff)) == $past(out_ff))

endmodule

/* tb/gpio_pin_controller_checker.sv */
module gpio_pin_controller_checker
   import gpc_pkg::*;
#(
   parameter int PIN_COUNT = 54
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [1:0]             req_func,
   input  logic [INDEX_BITS-1:0]  req_reg_index,
   input  logic [WORD_BITS-1:0]   req_write_data,
   input  logic [PIN_COUNT-1:0]   req_pin_levels,
   input  logic                   rsp_valid,
   input  logic [WORD_BITS-1:0]   rsp_read_data,
   input  logic [PIN_COUNT-1:0]   rsp_out_levels,
   input  logic [PIN_COUNT-1:0]   rsp_out_enable,
   input  logic [PIN_COUNT-1:0]   rsp_pull_up_pins,
   input  logic [PIN_COUNT-1:0]   rsp_pull_down_pins,
   input  logic                   rsp_event_irq,
   output int                     views_pending,
   output int                     mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [PIN_COUNT-1:0] pins_t;

   typedef struct packed {
      logic [WORD_BITS-1:0] read_data;
      pins_t                out_levels;
      pins_t                out_enable;
      pins_t                pull_up;
      pins_t                pull_down;
      logic                 irq;
   } pin_view_t;

   // predicted register bank
   logic [FSEL_BITS-1:0] fsel [PIN_COUNT];
   pins_t      out_latch, level_now, level_prev, event_bits;
   pins_t      rise_en, fall_en, arise_en, afall_en;
   pins_t      pull_up_q, pull_down_q;
   logic [1:0] pull_sel;

   pin_view_t  pin_views_due [$];

   function automatic pins_t place_half(logic hi, logic [WORD_BITS-1:0] d);
      logic [VEC_BITS-1:0] v;
      v = hi ? {d, {WORD_BITS{1'b0}}} : {{WORD_BITS{1'b0}}, d};
      return v[PIN_COUNT-1:0];
   endfunction

   function automatic logic [WORD_BITS-1:0] take_half(logic hi, pins_t v);
      logic [VEC_BITS-1:0] w;
      w = VEC_BITS'(v);
      return hi ? w[VEC_BITS-1:WORD_BITS] : w[WORD_BITS-1:0];
   endfunction

   function automatic pins_t merge_half(pins_t old, logic hi, logic [WORD_BITS-1:0] d);
      logic [VEC_BITS-1:0] w;
      w = (VEC_BITS'(old) & (hi ? KEEP_LOW : KEEP_HIGH)) | VEC_BITS'(place_half(hi, d));
      return w[PIN_COUNT-1:0];
   endfunction

   function automatic logic [WORD_BITS-1:0] bank_read(logic [INDEX_BITS-1:0] idx);
      logic [WORD_BITS-1:0] r;
      int pin;
      r = '0;
      if (idx < FSEL_WORDS) begin
         for (int k = 0; k < FSEL_PER_WORD; k++) begin
            pin = idx * FSEL_PER_WORD + k;
            if (pin < PIN_COUNT) r[FSEL_BITS*k +: FSEL_BITS] = fsel[pin];
         end
         return r;
      end
      case (idx)
         REG_LEV_LO, REG_LEV_HI:     r = take_half(idx == REG_LEV_HI, level_now);
         REG_EVT_LO, REG_EVT_HI:     r = take_half(idx == REG_EVT_HI, event_bits);
         REG_RISE_LO, REG_RISE_HI:   r = take_half(idx == REG_RISE_HI, rise_en);
         REG_FALL_LO, REG_FALL_HI:   r = take_half(idx == REG_FALL_HI, fall_en);
         REG_ARISE_LO, REG_ARISE_HI: r = take_half(idx == REG_ARISE_HI, arise_en);
         REG_AFALL_LO, REG_AFALL_HI: r = take_half(idx == REG_AFALL_HI, afall_en);
         REG_PULL:                   r = WORD_BITS'(pull_sel);
         default:                    r = '0;
      endcase
      return r;
   endfunction

   function automatic void bank_write(logic [INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] d);
      pins_t strobe;
      int    pin;
      if (idx < FSEL_WORDS) begin
         for (int k = 0; k < FSEL_PER_WORD; k++) begin
            pin = idx * FSEL_PER_WORD + k;
            if (pin < PIN_COUNT) fsel[pin] = d[FSEL_BITS*k +: FSEL_BITS];
         end
         return;
      end
      case (idx)
         REG_SET_LO, REG_SET_HI:     out_latch |= place_half(idx == REG_SET_HI, d);
         REG_CLR_LO, REG_CLR_HI:     out_latch &= ~place_half(idx == REG_CLR_HI, d);
         REG_EVT_LO, REG_EVT_HI:     event_bits &= ~place_half(idx == REG_EVT_HI, d);
         REG_RISE_LO, REG_RISE_HI:   rise_en = merge_half(rise_en, idx == REG_RISE_HI, d);
         REG_FALL_LO, REG_FALL_HI:   fall_en = merge_half(fall_en, idx == REG_FALL_HI, d);
         REG_ARISE_LO, REG_ARISE_HI: arise_en = merge_half(arise_en, idx == REG_ARISE_HI, d);
         REG_AFALL_LO, REG_AFALL_HI: afall_en = merge_half(afall_en, idx == REG_AFALL_HI, d);
         REG_PULL:                   pull_sel = d[1:0];
         REG_PCLK_LO, REG_PCLK_HI: begin
            strobe = place_half(idx == REG_PCLK_HI, d);
            pull_up_q &= ~strobe;
            pull_down_q &= ~strobe;
            if (pull_sel == PULL_DOWN) pull_down_q |= strobe;
            else if (pull_sel == PULL_UP) pull_up_q |= strobe;
         end
         default: ;
      endcase
   endfunction

   function automatic void sample_pins(pins_t levels);
      pins_t rise, fall;
      level_prev = level_now;
      level_now = levels;
      rise = level_now & ~level_prev;
      fall = ~level_now & level_prev;
      event_bits |= (rise & (rise_en | arise_en)) | (fall & (fall_en | afall_en));
   endfunction

   function automatic pins_t output_pins();
      pins_t oe;
      for (int p = 0; p < PIN_COUNT; p++) oe[p] = (fsel[p] == FSEL_OUTPUT);
      return oe;
   endfunction

   function automatic void report_field(string name, logic [VEC_BITS-1:0] want,
                                        logic [VEC_BITS-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      pin_view_t            want;
      logic [WORD_BITS-1:0] rd;
      if (reset) begin
         foreach (fsel[p]) fsel[p] = '0;
         out_latch = '0; level_now = '0; level_prev = '0; event_bits = '0;
         rise_en = '0; fall_en = '0; arise_en = '0; afall_en = '0;
         pull_up_q = '0; pull_down_q = '0; pull_sel = '0;
         pin_views_due.delete();
         views_pending <= 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (pin_views_due.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: response mismatch: expected none, actual read_data %h",
                        $time, rsp_read_data);
            end else begin
               want = pin_views_due.pop_front();
               report_field("read_data", VEC_BITS'(want.read_data), VEC_BITS'(rsp_read_data));
               report_field("out_levels", VEC_BITS'(want.out_levels), VEC_BITS'(rsp_out_levels));
               report_field("out_enable", VEC_BITS'(want.out_enable), VEC_BITS'(rsp_out_enable));
               report_field("pull_up_pins", VEC_BITS'(want.pull_up),
                            VEC_BITS'(rsp_pull_up_pins));
               report_field("pull_down_pins", VEC_BITS'(want.pull_down),
                            VEC_BITS'(rsp_pull_down_pins));
               report_field("event_irq", VEC_BITS'(want.irq), VEC_BITS'(rsp_event_irq));
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            rd = '0;
            case (req_func)
               FUNC_WRITE: bank_write(req_reg_index, req_write_data);
               FUNC_READ:  rd = bank_read(req_reg_index);
               FUNC_TICK:  sample_pins(req_pin_levels);
               default: ;
            endcase
            pin_views_due.push_back('{read_data: rd, out_levels: out_latch,
                                      out_enable: output_pins(), pull_up: pull_up_q,
                                      pull_down: pull_down_q, irq: |event_bits});
         end
         views_pending <= pin_views_due.size();
      end
   end

endmodule

/* tb/gpio_pin_controller_tb.sv */
module gpio_pin_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gpc_pkg::*;

   localparam int PIN_COUNT     = 54;
   localparam int RANDOM_ITEMS  = 1425;
   localparam int CYCLE_LIMIT   = 250_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RESET_CYCLES  = 10;

   // one of the dropped level-detect words: reads zero, ignores writes
   localparam logic [INDEX_BITS-1:0] REG_UNMAPPED = 6'd25;
   localparam logic [INDEX_BITS-1:0] REG_FSEL_0   = 6'd0;
   localparam logic [INDEX_BITS-1:0] REG_FSEL_5   = 6'd5;
   localparam logic [INDEX_BITS-1:0] LAST_INDEX   = 6'd39;
   // function select word with every field set to the output code
   localparam logic [WORD_BITS-1:0]  ALL_OUTPUTS  = 32'h0924_9249;

   typedef logic [PIN_COUNT-1:0] pins_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_func = FUNC_READ;
   logic [INDEX_BITS-1:0] req_reg_index = '0;
   logic [WORD_BITS-1:0]  req_write_data = '0;
   pins_t                 req_pin_levels = '0;
   logic                  rsp_valid;
   logic [WORD_BITS-1:0]  rsp_read_data;
   pins_t                 rsp_out_levels;
   pins_t                 rsp_out_enable;
   pins_t                 rsp_pull_up_pins;
   pins_t                 rsp_pull_down_pins;
   logic                  rsp_event_irq;

   int views_pending;
   int mismatch_count;
   int cycle_count = 0;

   pins_t last_levels = '0;

   initial begin
      forever #4 clock = ~clock;
   end

   gpio_pin_controller #(.PIN_COUNT(PIN_COUNT)) uut (
      .clock, .reset, .start, .busy,
      .req_func, .req_reg_index, .req_write_data, .req_pin_levels,
      .rsp_valid, .rsp_read_data, .rsp_out_levels, .rsp_out_enable,
      .rsp_pull_up_pins, .rsp_pull_down_pins, .rsp_event_irq
   );

   gpio_pin_controller_checker #(.PIN_COUNT(PIN_COUNT)) bank_check (
      .clock, .reset, .start, .busy,
      .req_func, .req_reg_index, .req_write_data, .req_pin_levels,
      .rsp_valid, .rsp_read_data, .rsp_out_levels, .rsp_out_enable,
      .rsp_pull_up_pins, .rsp_pull_down_pins, .rsp_event_irq,
      .views_pending, .mismatch_count
   );

   // Present one transaction and hold it until the edge where busy is low.
   task automatic issue(input func_type f, input logic [INDEX_BITS-1:0] idx,
                        input logic [WORD_BITS-1:0] data, input pins_t levels);
      start <= 1'b1;
      req_func <= f;
      req_reg_index <= idx;
      req_write_data <= data;
      req_pin_levels <= levels;
      do @(posedge clock); while (busy !== 1'b0);
      if (f == FUNC_TICK) last_levels = levels;
   endtask

   // Drop start for a gap of length n; zero means back-to-back transactions.
   task automatic hold_off(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drop start and stall until every predicted response has come back.
   // The first edge lets the checker count the last accepted transaction.
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (views_pending != 0) @(posedge clock);
   endtask

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Bias toward all-ones and all-zeros words so masks and strobes hit every bit.
   function automatic logic [WORD_BITS-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '1;
         1:       return '0;
         default: return $urandom();
      endcase
   endfunction

   // Mix full swings, single-pin toggles and fully random pin vectors so that
   // both isolated and wholesale edges reach the event logic.
   function automatic pins_t pick_levels(pins_t prev);
      logic [VEC_BITS-1:0] raw;
      raw = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
         0:          return '1;
         1:          return '0;
         2, 3, 4, 5: return prev ^ (pins_t'(1) << $urandom_range(0, PIN_COUNT - 1));
         default:    return raw[PIN_COUNT-1:0];
      endcase
   endfunction

   // Watchdog: fail the run once cycle_count reaches CYCLE_LIMIT.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int kind;
      bit quiet;
      logic [INDEX_BITS-1:0] idx;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Function select: all codes to seven on word 0 (top two bits dropped),
      // then every field of the last word to output, which leaves the absent
      // pins above the top one untouched.
      issue(FUNC_WRITE, REG_FSEL_0, '1, '0);
      issue(FUNC_WRITE, REG_FSEL_5, ALL_OUTPUTS, '0);
      issue(FUNC_READ, REG_FSEL_5, '0, '0);
      // Output latch: set everything (absent pins ignored), then clear every other pin of the low word.
      issue(FUNC_WRITE, REG_SET_LO, '1, '0);
      issue(FUNC_WRITE, REG_SET_HI, '1, '0);
      issue(FUNC_WRITE, REG_CLR_LO, 32'h5555_5555, '0);
      // Level words are read-only: this write must leave no trace.
      issue(FUNC_WRITE, REG_LEV_LO, '1, '0);
      // Arm edge detection in both sync and async form.
      issue(FUNC_WRITE, REG_RISE_HI, '1, '0);
      issue(FUNC_WRITE, REG_FALL_LO, '1, '0);
      issue(FUNC_WRITE, REG_ARISE_LO, 32'hAAAA_AAAA, '0);
      issue(FUNC_WRITE, REG_AFALL_HI, '1, '0);
      // Full rise, full fall, then an alternating pattern.
      issue(FUNC_TICK, REG_LEV_LO, '0, '1);
      issue(FUNC_TICK, REG_LEV_LO, '0, '0);
      issue(FUNC_TICK, REG_LEV_LO, '0, pins_t'({32{2'b10}}));
      issue(FUNC_READ, REG_EVT_LO, '0, '0);
      issue(FUNC_WRITE, REG_EVT_LO, '1, '0);
      issue(FUNC_READ, REG_LEV_HI, '0, '0);
      // Pull code keeps only its low bits: pull-down, pull-up, then off.
      issue(FUNC_WRITE, REG_PULL, 32'hFFFF_FFFD, '0);
      issue(FUNC_WRITE, REG_PCLK_LO, '1, '0);
      issue(FUNC_WRITE, REG_PULL, WORD_BITS'(PULL_UP), '0);
      issue(FUNC_WRITE, REG_PCLK_HI, '1, '0);
      issue(FUNC_WRITE, REG_PULL, '1, '0);
      issue(FUNC_WRITE, REG_PCLK_LO, 32'h0000_FFFF, '0);
      issue(FUNC_READ, REG_PULL, '0, '0);
      // Write-only and unmapped words read zero.
      issue(FUNC_READ, REG_SET_LO, '0, '0);
      issue(FUNC_READ, REG_UNMAPPED, '0, '0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Alternate stretches of back-to-back traffic with gappy traffic.
         quiet = ((i / 150) % 3) == 1;
         // Stall completely twice so the pipe runs empty mid-test.
         if (i == 480 || i == 960) drain_responses();
         else hold_off(pick_gap(quiet));

         kind = $urandom_range(0, 9);
         idx = INDEX_BITS'($urandom_range(0, LAST_INDEX));
         if (kind < 4)
            issue(FUNC_WRITE, idx, pick_word(), pick_levels(last_levels));
         else if (kind < 7)
            issue(FUNC_READ, idx, pick_word(), pick_levels(last_levels));
         else
            issue(FUNC_TICK, idx, pick_word(), pick_levels(last_levels));
      end

      drain_responses();
      // Let any stray response show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* gpio_pin_controller.f */
+incdir+hw/rtl
hw/rtl/gpc_pkg.sv
hw/rtl/gpc_regs.sv
hw/rtl/gpio_pin_controller.sv
tb/gpio_pin_controller_checker.sv
tb/gpio_pin_controller_tb.sv
